// ===== rtl/core/fct_pkg.sv =====
`default_nettype none

package fct_pkg;

   // default configuration
   localparam int NUM_PLANES_DEF = 6;
   localparam int COEF_WIDTH_DEF = 32;

   // field widths
   localparam int COORD_W    = 32;
   localparam int FUNC_W     = 2;
   localparam int SEL_W      = 3;
   localparam int REQ_DATA_W = 200;
   localparam int RSP_DATA_W = 8;

   // point culls when its distance (in 2^-32 units) lies strictly below this
   localparam int POINT_LIMIT = -429496730;

   // item function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_POINT = 2'd1,
      FUNC_BOX   = 2'd2
   } func_type;

   // pipeline control handed to each plane unit
   typedef struct packed {
      logic en_prod;
      logic en_sum;
      logic box_sel;
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/fct_plane.sv =====
`default_nettype none

module fct_plane
   import fct_pkg::*;
#(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ctl_type                    ctl,
   input  wire logic                       wr_en,
   input  wire logic signed [COORD_W-1:0]  first_x,
   input  wire logic signed [COORD_W-1:0]  first_y,
   input  wire logic signed [COORD_W-1:0]  first_z,
   input  wire logic signed [COORD_W-1:0]  second_x,
   input  wire logic signed [COORD_W-1:0]  second_y,
   input  wire logic signed [COORD_W-1:0]  second_z,
   output logic                            cull_point,
   output logic                            cull_box
);

   localparam int PW = COEF_WIDTH + COORD_W;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] LIMIT = SW'(POINT_LIMIT);

   logic signed [COEF_WIDTH-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic signed [COORD_W-1:0]    cx, cy, cz;
   logic signed [PW-1:0]         prod_x_in, prod_y_in, prod_z_in, prod_d_in;
   logic signed [PW-1:0]         prod_x_ff, prod_y_ff, prod_z_ff, prod_d_ff;
   logic signed [PW:0]           sum_xy_in, sum_zd_in, sum_xy_ff, sum_zd_ff;
   logic signed [SW-1:0]         total;

   // plane coefficients, wrapped or sign-extended to the stored width
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
         coef_d_ff <= '0;
      end else if (wr_en) begin
         coef_a_ff <= COEF_WIDTH'(first_x);
         coef_b_ff <= COEF_WIDTH'(first_y);
         coef_c_ff <= COEF_WIDTH'(first_z);
         coef_d_ff <= COEF_WIDTH'(second_x);
      end
   end

   // positive corner for boxes, the point itself otherwise
   always_comb begin
      cx = (ctl.box_sel && !coef_a_ff[COEF_WIDTH-1] && (coef_a_ff != '0)) ? second_x : first_x;
      cy = (ctl.box_sel && !coef_b_ff[COEF_WIDTH-1] && (coef_b_ff != '0)) ? second_y : first_y;
      cz = (ctl.box_sel && !coef_c_ff[COEF_WIDTH-1] && (coef_c_ff != '0)) ? second_z : first_z;
   end

   // exact products in Q32.32, d scaled up by 16 fraction bits
   always_comb begin
      prod_x_in = PW'(coef_a_ff) * PW'(cx);
      prod_y_in = PW'(coef_b_ff) * PW'(cy);
      prod_z_in = PW'(coef_c_ff) * PW'(cz);
      prod_d_in = PW'(coef_d_ff) <<< 16;
   end

   always_ff @(posedge clock) begin
      if (ctl.en_prod) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         prod_d_ff <= prod_d_in;
      end
   end

   // pair sums
   always_comb begin
      sum_xy_in = (PW+1)'(prod_x_ff) + (PW+1)'(prod_y_ff);
      sum_zd_in = (PW+1)'(prod_z_ff) + (PW+1)'(prod_d_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.en_sum) begin
         sum_xy_ff <= sum_xy_in;
         sum_zd_ff <= sum_zd_in;
      end
   end

   // final distance and thresholds
   always_comb begin
      total      = SW'(sum_xy_ff) + SW'(sum_zd_ff);
      cull_point = (total < LIMIT);
      cull_box   = total[SW-1];
   end

endmodule

`default_nettype wire

// ===== rtl/core/frustum_cull_test_top.sv =====
// frustum cull test
// Input words arrive on req_*: req_tuser carries the function (load plane,
// point test, box test), req_tdata the plane index and six Q16.16 values.
// A load writes plane (a, b, c, d) from first_x/y/z and second_x; a point
// test checks first_x/y/z against every plane; a box test checks the
// positive corner of the box [first, second] against every plane; a box
// with first_x > second_x passes. Every input word yields exactly one
// result word on rsp_*: rsp_tuser echoes the function, rsp_tdata[0] is the
// visible flag (0 for loads). Words pass the input register, the per-plane
// multiply stage, the pair-sum stage and the final add-and-compare stage
// in front of the result register; one word is taken per cycle unless
// stalled. A load takes effect for every word accepted after it.
// Reset clears all planes to zero (every test then reads visible) and
// empties the pipeline. When the receiver stalls, the result holds and
// the stages behind it keep filling; req_tready drops once all are full.
`default_nettype none

module frustum_cull_test_top
   import fct_pkg::*;
#(
   parameter int NUM_PLANES = NUM_PLANES_DEF,
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // plane_sel, first_x, first_y, first_z, second_x, second_y, second_z, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  wire logic [FUNC_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // visible, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // kind
   output logic [FUNC_W-1:0]          rsp_tuser
);

   // stage 0: input register
   logic                      s0_valid_ff;
   func_type                  s0_func_ff;
   logic [SEL_W-1:0]          s0_sel_ff;
   logic signed [COORD_W-1:0] s0_fx_ff, s0_fy_ff, s0_fz_ff;
   logic signed [COORD_W-1:0] s0_sx_ff, s0_sy_ff, s0_sz_ff;

   // stages 1 and 2: control that follows the products and sums
   logic     s1_valid_ff, s2_valid_ff;
   func_type s1_func_ff, s2_func_ff;
   logic     s1_inv_ff, s2_inv_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [FUNC_W-1:0]    rsp_kind_ff;
   logic                 rsp_vis_ff;
   logic                 rsp_vis_in;

   logic en1, en2, en3;
   logic load_go;
   logic s0_inv;
   ctl_type ctl;
   logic [NUM_PLANES-1:0] wr_en;
   logic [NUM_PLANES-1:0] cull_point;
   logic [NUM_PLANES-1:0] cull_box;

   // stage enables, each stage moves when the one after it has room
   always_comb begin
      en3        = !rsp_valid_ff || rsp_tready;
      en2        = !s2_valid_ff || en3;
      en1        = !s1_valid_ff || en2;
      req_tready = !s0_valid_ff || en1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s0_func_ff <= func_type'(req_tuser);
         s0_sel_ff  <= req_tdata[2:0];
         s0_fx_ff   <= req_tdata[34:3];
         s0_fy_ff   <= req_tdata[66:35];
         s0_fz_ff   <= req_tdata[98:67];
         s0_sx_ff   <= req_tdata[130:99];
         s0_sy_ff   <= req_tdata[162:131];
         s0_sz_ff   <= req_tdata[194:163];
      end
   end

   // plane writes happen as the load leaves stage 0
   always_comb begin
      load_go = s0_valid_ff && en1 && (s0_func_ff == FUNC_LOAD);
      for (int p = 0; p < NUM_PLANES; p++) begin
         wr_en[p] = load_go && (int'(s0_sel_ff) == p);
      end
      ctl.en_prod = en1;
      ctl.en_sum  = en2;
      ctl.box_sel = (s0_func_ff == FUNC_BOX);
      s0_inv      = (s0_fx_ff > s0_sx_ff);
   end

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      fct_plane #(
         .COEF_WIDTH (COEF_WIDTH)
      ) u_plane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_en      (wr_en[p]),
         .first_x    (s0_fx_ff),
         .first_y    (s0_fy_ff),
         .first_z    (s0_fz_ff),
         .second_x   (s0_sx_ff),
         .second_y   (s0_sy_ff),
         .second_z   (s0_sz_ff),
         .cull_point (cull_point[p]),
         .cull_box   (cull_box[p])
      );
   end

   // control pipeline alongside the plane units
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_func_ff <= s0_func_ff;
         s1_inv_ff  <= s0_inv;
      end
      if (en2) begin
         s2_func_ff <= s1_func_ff;
         s2_inv_ff  <= s1_inv_ff;
      end
   end

   // verdict from all planes
   always_comb begin
      unique case (s2_func_ff)
         FUNC_POINT: rsp_vis_in = !(|cull_point);
         FUNC_BOX:   rsp_vis_in = s2_inv_ff || !(|cull_box);
         default:    rsp_vis_in = 1'b0;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         rsp_kind_ff <= s2_func_ff;
         rsp_vis_ff  <= rsp_vis_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, rsp_vis_ff};

endmodule

`default_nettype wire

// ===== rtl/core/fct_checker.sv =====
`default_nettype none

module fct_checker
   import fct_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [FUNC_W-1:0]     rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a load acknowledge never reads visible
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == FUNC_LOAD) |-> !rsp_tdata[0])
      else $error("load acknowledge marked visible");

   // only the point and box tests can answer visible
   a_vis_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> (rsp_tuser == FUNC_POINT) || (rsp_tuser == FUNC_BOX))
      else $error("visible on a non-test word");

   // pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:1] == '0))
      else $error("result pad bits set");

endmodule

bind frustum_cull_test_top fct_checker u_fct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== test/frustum_cull_checker.sv =====
`timescale 1ns / 1ps

module frustum_cull_checker
   import fct_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // plane_sel, first_x, first_y, first_z, second_x, second_y, second_z, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  wire logic [FUNC_W-1:0]     req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // visible, zero pad
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   // kind
   input  wire logic [FUNC_W-1:0]     rsp_tuser,
   output int                         fail_count,
   output int                         pending,
   output int                         n_load,
   output int                         n_point,
   output int                         n_point_cull,
   output int                         n_box,
   output int                         n_box_cull,
   output int                         n_spare
);

   localparam int NPL = NUM_PLANES_DEF;
   // a point is culled when its distance (2^-32 units) lies strictly below this
   localparam longint POINT_EDGE = -64'sd429496730;

   typedef struct packed {
      logic [FUNC_W-1:0] kind;
      logic              visible;
   } verdict_type;

   verdict_type verdict_q[$];

   // plane table: a, b, c, d per plane
   logic signed [COORD_W-1:0] plane_a [NPL];
   logic signed [COORD_W-1:0] plane_b [NPL];
   logic signed [COORD_W-1:0] plane_c [NPL];
   logic signed [COORD_W-1:0] plane_d [NPL];

   int errors = 0;
   int words_out = 0;

   assign fail_count = errors;

   task automatic report_mismatch(string what, int want, int got);
      $display("%0t ns: result word %0d, %s: expected %0d, got %0d",
               $time, words_out, what, want, got);
      errors++;
   endtask

   // exact signed distance of a point to one plane, Q32.32
   function automatic logic signed [66:0] plane_dist(int p, logic signed [COORD_W-1:0] x,
         logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
      logic signed [66:0] acc;
      acc = plane_a[p] * x + plane_b[p] * y + plane_c[p] * z + plane_d[p] * 67'sd65536;
      return acc;
   endfunction

   // visibility of one word; a load updates the plane table
   function automatic logic predict_visible(logic [FUNC_W-1:0] fn, logic [SEL_W-1:0] sel,
         logic signed [COORD_W-1:0] fx, logic signed [COORD_W-1:0] fy,
         logic signed [COORD_W-1:0] fz, logic signed [COORD_W-1:0] sx,
         logic signed [COORD_W-1:0] sy, logic signed [COORD_W-1:0] sz);
      logic vis;
      logic signed [COORD_W-1:0] cx, cy, cz;
      vis = 1'b0;
      case (fn)
         FUNC_LOAD: begin
            if (sel < NPL) begin
               plane_a[sel] = fx;
               plane_b[sel] = fy;
               plane_c[sel] = fz;
               plane_d[sel] = sx;
            end
         end
         FUNC_POINT: begin
            vis = 1'b1;
            for (int p = 0; p < NPL; p++)
               if (plane_dist(p, fx, fy, fz) < POINT_EDGE) vis = 1'b0;
         end
         FUNC_BOX: begin
            vis = 1'b1;
            // inverted box in x always passes
            if (!(fx > sx)) begin
               for (int p = 0; p < NPL; p++) begin
                  cx = (plane_a[p] > 0) ? sx : fx;
                  cy = (plane_b[p] > 0) ? sy : fy;
                  cz = (plane_c[p] > 0) ? sz : fz;
                  if (plane_dist(p, cx, cy, cz) < 0) vis = 1'b0;
               end
            end
         end
         default: vis = 1'b0;
      endcase
      return vis;
   endfunction

   always @(posedge clock) begin
      verdict_type got, want;
      logic [FUNC_W-1:0] fn;
      if (reset) begin
         verdict_q.delete();
         for (int p = 0; p < NPL; p++) begin
            plane_a[p] = '0;
            plane_b[p] = '0;
            plane_c[p] = '0;
            plane_d[p] = '0;
         end
         n_load       = 0;
         n_point      = 0;
         n_point_cull = 0;
         n_box        = 0;
         n_box_cull   = 0;
         n_spare      = 0;
         pending <= 0;
      end else begin
         // compare an accepted result word with the oldest verdict
         if (rsp_tvalid && rsp_tready) begin
            got.kind    = rsp_tuser;
            got.visible = rsp_tdata[0];
            if (verdict_q.size() == 0) begin
               report_mismatch("word with nothing outstanding", -1, got.kind);
            end else begin
               want = verdict_q.pop_front();
               if (got.kind != want.kind)
                  report_mismatch("kind", want.kind, got.kind);
               if (got.visible != want.visible)
                  report_mismatch("visible", want.visible, got.visible);
            end
            words_out++;
         end
         // predict the verdict of an accepted input word
         if (req_tvalid && req_tready) begin
            fn = req_tuser;
            want.kind    = fn;
            want.visible = predict_visible(fn, req_tdata[SEL_W-1:0],
                  req_tdata[SEL_W +: COORD_W],
                  req_tdata[SEL_W + COORD_W +: COORD_W],
                  req_tdata[SEL_W + 2*COORD_W +: COORD_W],
                  req_tdata[SEL_W + 3*COORD_W +: COORD_W],
                  req_tdata[SEL_W + 4*COORD_W +: COORD_W],
                  req_tdata[SEL_W + 5*COORD_W +: COORD_W]);
            verdict_q.push_back(want);
            case (fn)
               FUNC_LOAD:  n_load++;
               FUNC_POINT: begin
                  n_point++;
                  if (!want.visible) n_point_cull++;
               end
               FUNC_BOX: begin
                  n_box++;
                  if (!want.visible) n_box_cull++;
               end
               default:    n_spare++;
            endcase
         end
         pending <= verdict_q.size();
      end
   end

endmodule

// ===== test/tb_frustum_cull_test_top.sv =====
`timescale 1ns / 1ps

module tb_frustum_cull_test_top;
   import fct_pkg::*;

   // function code with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int PAD_W          = REQ_DATA_W - SEL_W - 6*COORD_W;
   localparam int IDLE_LIMIT     = 4000;
   localparam int SQUEEZE_AT     = 400;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int RANDOM_WORDS   = 1030;

   localparam logic [COORD_W-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [COORD_W-1:0] Q_MAX = 32'h7fff_ffff;
   localparam logic [COORD_W-1:0] ONE   = 32'h0001_0000;
   // smallest point distance that still passes, and the first one culled
   localparam logic [COORD_W-1:0] EDGE_KEEP = -32'sd429496730;
   localparam logic [COORD_W-1:0] EDGE_CULL = -32'sd429496731;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [FUNC_W-1:0]     rsp_tuser;

   int fail_count, pending;
   int n_load, n_point, n_point_cull, n_box, n_box_cull, n_spare;

   int   words_in = 0;
   int   idle_cycles = 0;
   int   cycle_count = 0;
   int   rx_left = 0;
   int   rx_level = 0;
   logic squeezed = 1'b0;
   bit   no_gaps = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   frustum_cull_test_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   frustum_cull_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .fail_count   (fail_count),
      .pending      (pending),
      .n_load       (n_load),
      .n_point      (n_point),
      .n_point_cull (n_point_cull),
      .n_box        (n_box),
      .n_box_cull   (n_box_cull),
      .n_spare      (n_spare)
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // random Q16.16 value whose raw word lies in [-2^(bits-1), 2^(bits-1))
   function automatic logic [COORD_W-1:0] rand_q(int bits);
      logic signed [COORD_W-1:0] r;
      r = $urandom;
      return r >>> (COORD_W - bits);
   endfunction

   // progress watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_tvalid && req_tready) words_in <= words_in + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("frustum_cull_test_top: mismatch");
      $finish;
   end

   // result side: random stalls, plus one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_left    <= 0;
      end else if (rx_left > 0) begin
         rx_left <= rx_left - 1;
      end else if (!squeezed && words_in >= SQUEEZE_AT) begin
         rsp_tready <= 1'b0;
         rx_left    <= SQUEEZE_CYCLES;
         squeezed   <= 1'b1;
      end else if (rx_level != 0 &&
                   $urandom_range(0, (rx_level == 1) ? 7 : 2) == 0) begin
         rsp_tready <= 1'b0;
         rx_left    <= gap_len();
      end else begin
         rsp_tready <= 1'b1;
      end
      if (cycle_count % 64 == 0) rx_level <= $urandom_range(0, 2);
   end

   // offer one word and hold it until taken
   task automatic send_word(logic [FUNC_W-1:0] fn, logic [SEL_W-1:0] sel,
         logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy, logic [COORD_W-1:0] fz,
         logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy, logic [COORD_W-1:0] sz);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {{PAD_W{1'b0}}, sz, sy, sx, fz, fy, fx, sel};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = no_gaps ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // plane load: cleared, near axis-aligned slab side, or fully random
   task automatic load_random_plane();
      logic [COORD_W-1:0] c [4];
      logic [SEL_W-1:0] sel;
      int style, axis;
      style = $urandom_range(0, 3);
      axis  = $urandom_range(0, 2);
      sel   = ($urandom_range(0, 9) == 0) ? SEL_W'($urandom_range(6, 7))
                                          : SEL_W'($urandom_range(0, 5));
      for (int k = 0; k < 4; k++) c[k] = '0;
      if (style == 1 || style == 2) begin
         for (int k = 0; k < 3; k++) c[k] = rand_q($urandom_range(1, 12));
         c[axis] = $urandom_range(0, 1) ? ONE : -ONE;
         c[3]    = $urandom_range(0, 1 << 24);
      end else if (style == 3) begin
         for (int k = 0; k < 4; k++) c[k] = rand_q($urandom_range(1, 32));
      end
      send_word(FUNC_LOAD, sel, c[0], c[1], c[2], c[3], $urandom, $urandom);
   endtask

   // point, box or spare code with coordinates of a random scale
   task automatic send_test();
      logic [COORD_W-1:0] lo [3];
      logic [COORD_W-1:0] hi [3];
      int r, mag;
      r   = $urandom_range(0, 99);
      mag = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(14, 26);
      for (int k = 0; k < 3; k++) begin
         lo[k] = rand_q(mag);
         if ($urandom_range(0, 9) == 0)
            hi[k] = rand_q(mag);
         else
            hi[k] = lo[k] + $urandom_range(0, 1 << ((mag > 30) ? 30 : mag));
      end
      if (r < 48)
         send_word(FUNC_POINT, SEL_W'($urandom_range(0, 7)), lo[0], lo[1], lo[2],
                   $urandom, $urandom, $urandom);
      else if (r < 95)
         send_word(FUNC_BOX, SEL_W'($urandom_range(0, 7)), lo[0], lo[1], lo[2],
                   hi[0], hi[1], hi[2]);
      else
         send_word(FUNC_SPARE, SEL_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
   endtask

   initial begin
      int sent, n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table: every point and box test passes
      send_word(FUNC_POINT, 3'd0, '0, '0, '0, '0, '0, '0);
      send_word(FUNC_BOX, 3'd5, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
      send_word(FUNC_SPARE, 3'd7, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      // loads past the last plane change nothing
      send_word(FUNC_LOAD, 3'd6, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, '0);
      send_word(FUNC_LOAD, 3'd7, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
      send_word(FUNC_POINT, 3'd1, Q_MAX, Q_MAX, Q_MAX, '0, '0, '0);
      // plane 0 with the finest x step: point threshold and box sign
      send_word(FUNC_LOAD, 3'd0, 32'd1, '0, '0, '0, Q_MAX, Q_MIN);
      send_word(FUNC_POINT, 3'd2, EDGE_KEEP, '0, '0, Q_MAX, Q_MAX, Q_MAX);
      send_word(FUNC_POINT, 3'd4, EDGE_CULL, '0, '0, '0, '0, '0);
      send_word(FUNC_BOX, 3'd0, '1, '0, '0, '1, '0, '0);
      send_word(FUNC_BOX, 3'd3, '1, '0, '0, '0, '0, '0);
      // inverted box in x passes even though its corner is behind
      send_word(FUNC_BOX, 3'd0, 32'd5, '0, '0, -32'sd5, '0, '0);
      // inverted box in y is tested as given
      send_word(FUNC_LOAD, 3'd1, '0, -ONE, '0, '0, '0, '0);
      send_word(FUNC_BOX, 3'd0, '0, 32'd10, '0, 32'd10, -32'sd10, '0);
      send_word(FUNC_LOAD, 3'd1, '0, '0, '0, '0, '0, '0);
      // extreme coefficients and coordinates
      send_word(FUNC_LOAD, 3'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, '0);
      send_word(FUNC_POINT, 3'd0, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0);
      send_word(FUNC_POINT, 3'd0, Q_MAX, Q_MAX, Q_MAX, '0, '0, '0);
      send_word(FUNC_BOX, 3'd0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
      send_word(FUNC_LOAD, 3'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, '0, '0);
      send_word(FUNC_POINT, 3'd0, Q_MAX, Q_MAX, Q_MAX, '0, '0, '0);
      send_word(FUNC_POINT, 3'd0, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0);
      send_word(FUNC_BOX, 3'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      send_word(FUNC_LOAD, 3'd0, '0, '0, '0, '0, '0, '0);

      // random frames: a few plane loads, then a run of tests
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         no_gaps = ($urandom_range(0, 9) < 3);
         n = $urandom_range(1, 8);
         repeat (n) load_random_plane();
         sent += n;
         n = $urandom_range(8, 40);
         repeat (n) send_test();
         sent += n;
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      // drain
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d words: %0d plane loads, %0d points (%0d culled),",
               words_in, n_load, n_point, n_point_cull);
      $display("%0d boxes (%0d culled), %0d spare codes; receiver held off %0d cycles once",
               n_box, n_box_cull, n_spare, SQUEEZE_CYCLES);
      if (fail_count == 0)
         $display("frustum_cull_test_top: match");
      else
         $display("frustum_cull_test_top: mismatch");
      $finish;
   end

endmodule
